@@ design/tgc_pkg.sv @@
// tgc_pkg: shared types and constants of the touch gesture classifier
// no dependencies; used by every module of the block

package tgc_pkg;

	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int TIME_W    = 32;
	localparam int OUT_POS_W = 16;
	localparam int DELTA_W   = 17;
	localparam int DIST_W    = 18;

	typedef enum logic [1:0] {
		OP_TRACK_ID = 2'd0,
		OP_POS_X    = 2'd1,
		OP_POS_Y    = 2'd2,
		OP_OTHER    = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		KIND_NONE        = 4'd0,
		KIND_DOWN        = 4'd1,
		KIND_MOVE        = 4'd2,
		KIND_TAP         = 4'd3,
		KIND_DOUBLE_TAP  = 4'd4,
		KIND_LONG_PRESS  = 4'd5,
		KIND_SWIPE_LEFT  = 4'd6,
		KIND_SWIPE_RIGHT = 4'd7,
		KIND_SWIPE_UP    = 4'd8,
		KIND_SWIPE_DOWN  = 4'd9
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TAP_MAX_TIME      = 3'd0,
		CFG_TAP_MOVE_LIM      = 3'd1,
		CFG_LONG_PRESS_TIME   = 3'd2,
		CFG_SWIPE_MOVE_MIN    = 3'd3,
		CFG_DOUBLE_TAP_WINDOW = 3'd4,
		CFG_DOUBLE_TAP_RADIUS = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [CFG_W-1:0] tap_max_time;
		logic [CFG_W-1:0] tap_move_lim;
		logic [CFG_W-1:0] long_press_time;
		logic [CFG_W-1:0] swipe_move_min;
		logic [CFG_W-1:0] double_tap_window;
		logic [CFG_W-1:0] double_tap_radius;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		tap_max_time:      16'd200,
		tap_move_lim:      16'd20,
		long_press_time:   16'd800,
		swipe_move_min:    16'd50,
		double_tap_window: 16'd400,
		double_tap_radius: 16'd30
	};

	// event in the work stage
	typedef struct packed {
		logic fire;
		op_t  op;
		logic neg;
	} evt_t;

	// slot lookup status of the event in the work stage
	typedef struct packed {
		logic found;
		logic is_rel;
	} hit_t;

endpackage

@@ design/tgc_cfg_regs.sv @@
// tgc_cfg_regs: threshold registers written through the configuration port
// depends on tgc_pkg

module tgc_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tgc_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [tgc_pkg::CFG_W-1:0]     cfg_data,
	output tgc_pkg::cfg_t                 cfg
);

	tgc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= tgc_pkg::CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				tgc_pkg::CFG_TAP_MAX_TIME:      cfg_q.tap_max_time      <= cfg_data;
				tgc_pkg::CFG_TAP_MOVE_LIM:      cfg_q.tap_move_lim      <= cfg_data;
				tgc_pkg::CFG_LONG_PRESS_TIME:   cfg_q.long_press_time   <= cfg_data;
				tgc_pkg::CFG_SWIPE_MOVE_MIN:    cfg_q.swipe_move_min    <= cfg_data;
				tgc_pkg::CFG_DOUBLE_TAP_WINDOW: cfg_q.double_tap_window <= cfg_data;
				tgc_pkg::CFG_DOUBLE_TAP_RADIUS: cfg_q.double_tap_radius <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ design/tgc_slot_table.sv @@
// tgc_slot_table: touch point slots with priority encoders for free and active slots
// depends on tgc_pkg

module tgc_slot_table #(
	parameter int SLOTS      = 10,
	parameter int COORD_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tgc_pkg::evt_t                    evt,
	input  logic [COORD_BITS-1:0]            coord,
	input  logic [tgc_pkg::TIME_W-1:0]       now,
	output tgc_pkg::hit_t                    hit,
	output logic [COORD_BITS-1:0]            pt_x,
	output logic [COORD_BITS-1:0]            pt_y,
	output logic [COORD_BITS-1:0]            start_x,
	output logic [COORD_BITS-1:0]            start_y,
	output logic [tgc_pkg::TIME_W-1:0]       start_time
);

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic [SLOTS-1:0]             active_q;
	logic [COORD_BITS-1:0]        x_q       [SLOTS];
	logic [COORD_BITS-1:0]        y_q       [SLOTS];
	logic [COORD_BITS-1:0]        start_x_q [SLOTS];
	logic [COORD_BITS-1:0]        start_y_q [SLOTS];
	logic [tgc_pkg::TIME_W-1:0]   start_t_q [SLOTS];

	logic [SLOT_W-1:0] low_free;
	logic [SLOT_W-1:0] low_act;
	logic [SLOT_W-1:0] high_act;
	logic              any_free;
	logic              any_act;
	logic              is_down;
	logic              is_rel;
	logic              is_pos;
	logic              found;

	always_comb begin
		low_free = '0;
		low_act  = '0;
		high_act = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				low_free = SLOT_W'(i);
			end
			if (active_q[i]) begin
				low_act = SLOT_W'(i);
			end
		end
		for (int i = 0; i < SLOTS; i++) begin
			if (active_q[i]) begin
				high_act = SLOT_W'(i);
			end
		end
	end

	assign any_free = ~&active_q;
	assign any_act  = |active_q;

	assign is_down = (evt.op == tgc_pkg::OP_TRACK_ID) && !evt.neg;
	assign is_rel  = (evt.op == tgc_pkg::OP_TRACK_ID) && evt.neg;
	assign is_pos  = (evt.op == tgc_pkg::OP_POS_X) || (evt.op == tgc_pkg::OP_POS_Y);
	assign found   = (is_down && any_free) || ((is_rel || is_pos) && any_act);

	assign hit.found  = found;
	assign hit.is_rel = is_rel && any_act;

	always_comb begin
		pt_x = '0;
		pt_y = '0;
		priority if (is_down) begin
			pt_x = x_q[low_free];
			pt_y = y_q[low_free];
		end else if (is_rel) begin
			pt_x = x_q[low_act];
			pt_y = y_q[low_act];
		end else if (is_pos) begin
			pt_x = (evt.op == tgc_pkg::OP_POS_X) ? coord : x_q[high_act];
			pt_y = (evt.op == tgc_pkg::OP_POS_Y) ? coord : y_q[high_act];
		end else begin
		end
	end

	assign start_x    = start_x_q[low_act];
	assign start_y    = start_y_q[low_act];
	assign start_time = start_t_q[low_act];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				x_q[i] <= '0;
				y_q[i] <= '0;
			end
		end else if (evt.fire && found) begin
			priority if (is_down) begin
				active_q[low_free] <= 1'b1;
			end else if (is_rel) begin
				active_q[low_act] <= 1'b0;
			end else if (evt.op == tgc_pkg::OP_POS_X) begin
				x_q[high_act] <= coord;
			end else begin
				y_q[high_act] <= coord;
			end
		end
	end

	// start point is only read while the slot is active
	always_ff @(posedge clk) begin
		if (evt.fire && found && is_down) begin
			start_x_q[low_free] <= x_q[low_free];
			start_y_q[low_free] <= y_q[low_free];
			start_t_q[low_free] <= now;
		end
	end

`ifndef SYNTHESIS
	a_release_frees_one: assert property (@(posedge clk) disable iff (!arst_n)
		evt.fire && is_rel && any_act |=>
		$countones(active_q) + 1 == $countones($past(active_q)))
		else $error("release did not free exactly one slot");

	a_down_claims_one: assert property (@(posedge clk) disable iff (!arst_n)
		evt.fire && is_down && any_free |=>
		$countones(active_q) == $countones($past(active_q)) + 1)
		else $error("touch-down did not claim exactly one slot");
`endif

endmodule

@@ design/tgc_classify.sv @@
// tgc_classify: release classification by duration and distance, keeps the last tap
// depends on tgc_pkg

module tgc_classify #(
	parameter int COORD_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 commit,
	input  tgc_pkg::cfg_t                        cfg,
	input  logic [tgc_pkg::TIME_W-1:0]           now,
	input  logic [COORD_BITS-1:0]                cur_x,
	input  logic [COORD_BITS-1:0]                cur_y,
	input  logic [COORD_BITS-1:0]                start_x,
	input  logic [COORD_BITS-1:0]                start_y,
	input  logic [tgc_pkg::TIME_W-1:0]           start_time,
	output tgc_pkg::kind_t                       kind,
	output logic signed [tgc_pkg::DELTA_W-1:0]   delta_x,
	output logic signed [tgc_pkg::DELTA_W-1:0]   delta_y
);

	logic [tgc_pkg::TIME_W-1:0] last_tap_time_q;
	logic [COORD_BITS-1:0]      last_tap_x_q;
	logic [COORD_BITS-1:0]      last_tap_y_q;

	logic [tgc_pkg::TIME_W-1:0] duration;
	logic [tgc_pkg::TIME_W-1:0] since;
	logic signed [COORD_BITS:0] dx;
	logic signed [COORD_BITS:0] dy;
	logic signed [COORD_BITS:0] ex;
	logic signed [COORD_BITS:0] ey;
	logic [COORD_BITS-1:0]      adx;
	logic [COORD_BITS-1:0]      ady;
	logic [COORD_BITS-1:0]      aex;
	logic [COORD_BITS-1:0]      aey;
	logic [COORD_BITS:0]        mdist;
	logic [tgc_pkg::DIST_W-1:0] dist_w;
	logic                       still;
	logic                       is_tap;
	logic                       is_double;
	logic                       is_long;
	logic                       is_swipe;

	assign duration = now - start_time;
	assign since    = now - last_tap_time_q;

	assign dx = $signed({1'b0, cur_x}) - $signed({1'b0, start_x});
	assign dy = $signed({1'b0, cur_y}) - $signed({1'b0, start_y});
	assign ex = $signed({1'b0, cur_x}) - $signed({1'b0, last_tap_x_q});
	assign ey = $signed({1'b0, cur_y}) - $signed({1'b0, last_tap_y_q});

	assign adx = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
	assign ady = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
	assign aex = ex[COORD_BITS] ? COORD_BITS'(-ex) : ex[COORD_BITS-1:0];
	assign aey = ey[COORD_BITS] ? COORD_BITS'(-ey) : ey[COORD_BITS-1:0];

	assign mdist  = {1'b0, adx} + {1'b0, ady};
	assign dist_w = tgc_pkg::DIST_W'(mdist);

	assign still    = dist_w < tgc_pkg::DIST_W'(cfg.tap_move_lim);
	assign is_tap   = (duration < tgc_pkg::TIME_W'(cfg.tap_max_time)) && still;
	assign is_long  = (duration >= tgc_pkg::TIME_W'(cfg.long_press_time)) && still;
	assign is_swipe = dist_w >= tgc_pkg::DIST_W'(cfg.swipe_move_min);
	assign is_double = (since < tgc_pkg::TIME_W'(cfg.double_tap_window))
		&& (tgc_pkg::CFG_W'(aex) < cfg.double_tap_radius)
		&& (tgc_pkg::CFG_W'(aey) < cfg.double_tap_radius);

	always_comb begin
		kind    = tgc_pkg::KIND_NONE;
		delta_x = '0;
		delta_y = '0;
		priority if (is_tap) begin
			kind = is_double ? tgc_pkg::KIND_DOUBLE_TAP : tgc_pkg::KIND_TAP;
		end else if (is_long) begin
			kind = tgc_pkg::KIND_LONG_PRESS;
		end else if (is_swipe) begin
			if (adx > ady) begin
				kind = (!dx[COORD_BITS] && (dx != '0)) ?
					tgc_pkg::KIND_SWIPE_RIGHT : tgc_pkg::KIND_SWIPE_LEFT;
			end else begin
				kind = (!dy[COORD_BITS] && (dy != '0)) ?
					tgc_pkg::KIND_SWIPE_DOWN : tgc_pkg::KIND_SWIPE_UP;
			end
			delta_x = tgc_pkg::DELTA_W'(dx);
			delta_y = tgc_pkg::DELTA_W'(dy);
		end else begin
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_tap_time_q <= '0;
			last_tap_x_q    <= '0;
			last_tap_y_q    <= '0;
		end else if (commit && is_tap) begin
			last_tap_time_q <= now;
			last_tap_x_q    <= cur_x;
			last_tap_y_q    <= cur_y;
		end
	end

`ifndef SYNTHESIS
	a_tap_records_time: assert property (@(posedge clk) disable iff (!arst_n)
		commit && is_tap |=> last_tap_time_q == $past(now))
		else $error("tap did not record its time");
`endif

endmodule

@@ design/touch_gesture_classifier.sv @@
// touch_gesture_classifier: top level, input register, slot table, classifier, result register
// depends on tgc_pkg, tgc_cfg_regs, tgc_slot_table, tgc_classify
//
// channel | handshake            | payload
// cfg     | cfg_we               | cfg_idx, cfg_data
// in      | in_valid / in_ready  | op, value, now_ms
// out     | out_valid / out_ready| gesture_kind, gesture_x, gesture_y, delta_x, delta_y
//
// one item per cycle unless the output stalls; each item yields one result
// slot search, state update and classification sit between the input and result registers
// reset clears slots and last tap and loads the default thresholds at once; no clearing pass
// a stalled output holds the result register and the input register keeps one item behind it

module touch_gesture_classifier #(
	parameter int SLOTS      = 10,
	parameter int COORD_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [tgc_pkg::CFG_IDX_W-1:0]         cfg_idx,
	input  logic [tgc_pkg::CFG_W-1:0]             cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [1:0]                            op,
	input  logic signed [16:0]                    value,
	input  logic [tgc_pkg::TIME_W-1:0]            now_ms,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [3:0]                            gesture_kind,
	output logic [tgc_pkg::OUT_POS_W-1:0]         gesture_x,
	output logic [tgc_pkg::OUT_POS_W-1:0]         gesture_y,
	output logic signed [tgc_pkg::DELTA_W-1:0]    delta_x,
	output logic signed [tgc_pkg::DELTA_W-1:0]    delta_y
);

	logic                              valid_s1;
	tgc_pkg::op_t                      op_s1;
	logic                              neg_s1;
	logic [COORD_BITS-1:0]             coord_s1;
	logic [tgc_pkg::TIME_W-1:0]        now_s1;

	logic                              valid_s2;
	tgc_pkg::kind_t                    kind_s2;
	logic [tgc_pkg::OUT_POS_W-1:0]     x_s2;
	logic [tgc_pkg::OUT_POS_W-1:0]     y_s2;
	logic signed [tgc_pkg::DELTA_W-1:0] dx_s2;
	logic signed [tgc_pkg::DELTA_W-1:0] dy_s2;

	logic                              advance;
	logic                              fire;
	tgc_pkg::cfg_t                     cfg;
	tgc_pkg::evt_t                     evt;
	tgc_pkg::hit_t                     hit;
	logic [COORD_BITS-1:0]             pt_x;
	logic [COORD_BITS-1:0]             pt_y;
	logic [COORD_BITS-1:0]             start_x;
	logic [COORD_BITS-1:0]             start_y;
	logic [tgc_pkg::TIME_W-1:0]        start_time;
	tgc_pkg::kind_t                    cls_kind;
	logic signed [tgc_pkg::DELTA_W-1:0] cls_dx;
	logic signed [tgc_pkg::DELTA_W-1:0] cls_dy;

	tgc_pkg::kind_t                    res_kind;
	logic signed [tgc_pkg::DELTA_W-1:0] res_dx;
	logic signed [tgc_pkg::DELTA_W-1:0] res_dy;

	assign advance  = !valid_s2 || out_ready;
	assign fire     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1    <= tgc_pkg::op_t'(op);
			neg_s1   <= value[16];
			coord_s1 <= value[COORD_BITS-1:0];
			now_s1   <= now_ms;
		end
	end

	assign evt.fire = fire;
	assign evt.op   = op_s1;
	assign evt.neg  = neg_s1;

	tgc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	tgc_slot_table #(
		.SLOTS      (SLOTS),
		.COORD_BITS (COORD_BITS)
	) u_slots (
		.clk        (clk),
		.arst_n     (arst_n),
		.evt        (evt),
		.coord      (coord_s1),
		.now        (now_s1),
		.hit        (hit),
		.pt_x       (pt_x),
		.pt_y       (pt_y),
		.start_x    (start_x),
		.start_y    (start_y),
		.start_time (start_time)
	);

	tgc_classify #(
		.COORD_BITS (COORD_BITS)
	) u_cls (
		.clk        (clk),
		.arst_n     (arst_n),
		.commit     (fire && hit.is_rel),
		.cfg        (cfg),
		.now        (now_s1),
		.cur_x      (pt_x),
		.cur_y      (pt_y),
		.start_x    (start_x),
		.start_y    (start_y),
		.start_time (start_time),
		.kind       (cls_kind),
		.delta_x    (cls_dx),
		.delta_y    (cls_dy)
	);

	always_comb begin
		res_kind = tgc_pkg::KIND_NONE;
		res_dx   = '0;
		res_dy   = '0;
		priority if (!hit.found) begin
		end else if (hit.is_rel) begin
			res_kind = cls_kind;
			res_dx   = cls_dx;
			res_dy   = cls_dy;
		end else if (op_s1 == tgc_pkg::OP_TRACK_ID) begin
			res_kind = tgc_pkg::KIND_DOWN;
		end else begin
			res_kind = tgc_pkg::KIND_MOVE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			kind_s2 <= res_kind;
			x_s2    <= hit.found ? tgc_pkg::OUT_POS_W'(pt_x) : '0;
			y_s2    <= hit.found ? tgc_pkg::OUT_POS_W'(pt_y) : '0;
			dx_s2   <= res_dx;
			dy_s2   <= res_dy;
		end
	end

	assign out_valid    = valid_s2;
	assign gesture_kind = kind_s2;
	assign gesture_x    = x_s2;
	assign gesture_y    = y_s2;
	assign delta_x      = dx_s2;
	assign delta_y      = dy_s2;

`ifndef SYNTHESIS
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> in_ready)
		else $error("input stalled while the result register is empty");

	a_delta_only_swipe: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && kind_s2 != tgc_pkg::KIND_SWIPE_LEFT
		&& kind_s2 != tgc_pkg::KIND_SWIPE_RIGHT
		&& kind_s2 != tgc_pkg::KIND_SWIPE_UP
		&& kind_s2 != tgc_pkg::KIND_SWIPE_DOWN |-> dx_s2 == '0 && dy_s2 == '0)
		else $error("nonzero displacement on a result that is no swipe");
`endif

endmodule

@@ test/tb.sv @@
// tb: self-checking testbench for touch_gesture_classifier
// holds a scoreboard class that predicts each gesture result, plus tasks that drive
// touch events and threshold writes; depends on tgc_pkg and the block's RTL

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 10;
	localparam int NPHASE = 9;
	localparam int PER_PHASE = 100;

	typedef struct packed {
		tgc_pkg::kind_t kind;
		logic [15:0] x;
		logic [15:0] y;
		logic signed [16:0] dx;
		logic signed [16:0] dy;
	} gesture_t;

	class gesture_scoreboard;
		tgc_pkg::cfg_t thr;
		bit active [SLOTS];
		logic [15:0] pos_x [SLOTS];
		logic [15:0] pos_y [SLOTS];
		logic [15:0] org_x [SLOTS];
		logic [15:0] org_y [SLOTS];
		logic [31:0] t_down [SLOTS];
		logic [31:0] tap_t;
		logic [15:0] tap_x;
		logic [15:0] tap_y;
		gesture_t expected_q [$];
		int mismatches;
		int checked;
		int events;
		int dropped;
		int kind_cnt [10];

		function new();
			thr = tgc_pkg::CFG_RESET;
			foreach (active[i]) begin
				active[i] = 1'b0;
				pos_x[i] = '0;
				pos_y[i] = '0;
				org_x[i] = '0;
				org_y[i] = '0;
				t_down[i] = '0;
			end
			foreach (kind_cnt[i])
				kind_cnt[i] = 0;
			tap_t = '0;
			tap_x = '0;
			tap_y = '0;
			mismatches = 0;
			checked = 0;
			events = 0;
			dropped = 0;
		endfunction

		function void set_threshold(tgc_pkg::cfg_idx_t idx, logic [15:0] v);
			case (idx)
				tgc_pkg::CFG_TAP_MAX_TIME:      thr.tap_max_time = v;
				tgc_pkg::CFG_TAP_MOVE_LIM:      thr.tap_move_lim = v;
				tgc_pkg::CFG_LONG_PRESS_TIME:   thr.long_press_time = v;
				tgc_pkg::CFG_SWIPE_MOVE_MIN:    thr.swipe_move_min = v;
				tgc_pkg::CFG_DOUBLE_TAP_WINDOW: thr.double_tap_window = v;
				tgc_pkg::CFG_DOUBLE_TAP_RADIUS: thr.double_tap_radius = v;
				default: ;
			endcase
		endfunction

		function void top_point(output logic [15:0] x, output logic [15:0] y);
			x = '0;
			y = '0;
			for (int s = 0; s < SLOTS; s++)
				if (active[s]) begin
					x = pos_x[s];
					y = pos_y[s];
				end
		endfunction

		function gesture_t classify_release(int s, logic [31:0] now);
			gesture_t g;
			logic [31:0] held;
			logic [31:0] since;
			int px, py, sx, sy, dx, dy, adx, ady, mdist, ex, ey;
			g = '0;
			g.x = pos_x[s];
			g.y = pos_y[s];
			held = now - t_down[s];
			px = pos_x[s];
			py = pos_y[s];
			sx = org_x[s];
			sy = org_y[s];
			dx = px - sx;
			dy = py - sy;
			adx = (dx < 0) ? -dx : dx;
			ady = (dy < 0) ? -dy : dy;
			mdist = adx + ady;
			if (held < thr.tap_max_time && mdist < int'(thr.tap_move_lim)) begin
				since = now - tap_t;
				ex = px - int'(tap_x);
				ey = py - int'(tap_y);
				if (ex < 0)
					ex = -ex;
				if (ey < 0)
					ey = -ey;
				if (since < thr.double_tap_window && ex < int'(thr.double_tap_radius)
						&& ey < int'(thr.double_tap_radius))
					g.kind = tgc_pkg::KIND_DOUBLE_TAP;
				else
					g.kind = tgc_pkg::KIND_TAP;
				tap_t = now;
				tap_x = pos_x[s];
				tap_y = pos_y[s];
			end else if (held >= thr.long_press_time && mdist < int'(thr.tap_move_lim)) begin
				g.kind = tgc_pkg::KIND_LONG_PRESS;
			end else if (mdist >= int'(thr.swipe_move_min)) begin
				if (adx > ady)
					g.kind = (dx > 0) ? tgc_pkg::KIND_SWIPE_RIGHT : tgc_pkg::KIND_SWIPE_LEFT;
				else
					g.kind = (dy > 0) ? tgc_pkg::KIND_SWIPE_DOWN : tgc_pkg::KIND_SWIPE_UP;
				g.dx = dx[16:0];
				g.dy = dy[16:0];
			end
			active[s] = 1'b0;
			return g;
		endfunction

		function void note_event(tgc_pkg::op_t o, logic signed [16:0] v, logic [31:0] now);
			gesture_t g;
			bit done;
			g = '0;
			done = 1'b0;
			events++;
			case (o)
				tgc_pkg::OP_TRACK_ID: begin
					if (!v[16]) begin
						for (int s = 0; s < SLOTS; s++)
							if (!done && !active[s]) begin
								active[s] = 1'b1;
								t_down[s] = now;
								org_x[s] = pos_x[s];
								org_y[s] = pos_y[s];
								g.kind = tgc_pkg::KIND_DOWN;
								g.x = pos_x[s];
								g.y = pos_y[s];
								done = 1'b1;
							end
						if (!done)
							dropped++;
					end else begin
						for (int s = 0; s < SLOTS; s++)
							if (!done && active[s]) begin
								g = classify_release(s, now);
								done = 1'b1;
							end
					end
				end
				tgc_pkg::OP_POS_X, tgc_pkg::OP_POS_Y: begin
					for (int s = SLOTS - 1; s >= 0; s--)
						if (!done && active[s]) begin
							if (o == tgc_pkg::OP_POS_X)
								pos_x[s] = v[15:0];
							else
								pos_y[s] = v[15:0];
							g.kind = tgc_pkg::KIND_MOVE;
							g.x = pos_x[s];
							g.y = pos_y[s];
							done = 1'b1;
						end
				end
				default: ;
			endcase
			expected_q.push_back(g);
		endfunction

		function void check_gesture(gesture_t got);
			gesture_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: kind %0d x %0d y %0d dx %0d dy %0d",
						got.kind, got.x, got.y, got.dx, got.dy);
				return;
			end
			want = expected_q.pop_front();
			checked++;
			kind_cnt[want.kind]++;
			if (got.kind !== want.kind || got.x !== want.x || got.y !== want.y
					|| got.dx !== want.dx || got.dy !== want.dy) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("result %0d: expected kind %0d x %0d y %0d dx %0d dy %0d",
						checked, want.kind, want.x, want.y, want.dx, want.dy);
					$display("  got kind %0d x %0d y %0d dx %0d dy %0d",
						got.kind, got.x, got.y, got.dx, got.dy);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [tgc_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [tgc_pkg::CFG_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [1:0] op;
	logic signed [16:0] value;
	logic [tgc_pkg::TIME_W-1:0] now_ms;
	logic out_valid;
	logic out_ready;
	logic [3:0] gesture_kind;
	logic [tgc_pkg::OUT_POS_W-1:0] gesture_x;
	logic [tgc_pkg::OUT_POS_W-1:0] gesture_y;
	logic signed [tgc_pkg::DELTA_W-1:0] delta_x;
	logic signed [tgc_pkg::DELTA_W-1:0] delta_y;

	gesture_scoreboard sb;
	logic [31:0] now_t;
	int items;
	bit src_quiet;
	bit snk_quiet;

	touch_gesture_classifier u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.value        (value),
		.now_ms       (now_ms),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.gesture_kind (gesture_kind),
		.gesture_x    (gesture_x),
		.gesture_y    (gesture_y),
		.delta_x      (delta_x),
		.delta_y      (delta_y)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap(bit quiet);
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int near(int lim);
		case ($urandom_range(0, 4))
			0: return (lim > 0) ? lim - 1 : 0;
			1: return lim;
			2: return lim + 1;
			default: return $urandom_range(0, lim + lim / 2 + 2);
		endcase
	endfunction

	function automatic logic signed [16:0] coord_at(int base, int off);
		int c;
		c = base + off;
		if (c < 0)
			c = 0;
		if (c > 65535)
			c = 65535;
		return c[16:0];
	endfunction

	function automatic int pause_ms();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return near(sb.thr.double_tap_window);
			6, 7: return $urandom_range(0, 5000);
			8: return $urandom();
			default: return 0;
		endcase
	endfunction

	function automatic tgc_pkg::cfg_t phase_setting(int ph);
		tgc_pkg::cfg_t c;
		case (ph)
			2: c = '0;
			3: c = '1;
			5: begin
				c = '1;
				c.tap_move_lim = 16'($urandom_range(0, 60));
				c.swipe_move_min = '0;
				c.double_tap_radius = 16'($urandom_range(0, 1));
			end
			8: c = tgc_pkg::CFG_RESET;
			default: begin
				c.tap_max_time = 16'($urandom_range(0, 400));
				c.tap_move_lim = 16'($urandom_range(0, 80));
				c.long_press_time = 16'($urandom_range(0, 1500));
				c.swipe_move_min = 16'($urandom_range(0, 200));
				c.double_tap_window = 16'($urandom_range(0, 800));
				c.double_tap_radius = 16'($urandom_range(0, 100));
			end
		endcase
		return c;
	endfunction

	task automatic send_event(tgc_pkg::op_t o, logic signed [16:0] v, logic [31:0] t);
		int gap;
		gap = pick_gap(src_quiet);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		value <= v;
		now_ms <= t;
		do @(posedge clk); while (!in_ready);
		sb.note_event(o, v, t);
		if (o != tgc_pkg::OP_OTHER)
			items++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(tgc_pkg::cfg_idx_t idx, logic [15:0] d);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= d;
		@(posedge clk);
		sb.set_threshold(idx, d);
	endtask

	task automatic set_thresholds(tgc_pkg::cfg_t c);
		write_reg(tgc_pkg::CFG_TAP_MAX_TIME, c.tap_max_time);
		write_reg(tgc_pkg::CFG_TAP_MOVE_LIM, c.tap_move_lim);
		write_reg(tgc_pkg::CFG_LONG_PRESS_TIME, c.long_press_time);
		write_reg(tgc_pkg::CFG_SWIPE_MOVE_MIN, c.swipe_move_min);
		write_reg(tgc_pkg::CFG_DOUBLE_TAP_WINDOW, c.double_tap_window);
		write_reg(tgc_pkg::CFG_DOUBLE_TAP_RADIUS, c.double_tap_radius);
		cfg_we <= 1'b0;
	endtask

	task automatic run_directed();
		send_event(tgc_pkg::OP_TRACK_ID, -17'sd1, 32'd0);
		send_event(tgc_pkg::OP_POS_X, 17'sd100, 32'd0);
		send_event(tgc_pkg::OP_OTHER, 17'sd5, 32'd0);
		// first tap compares against the cleared last-tap record
		send_event(tgc_pkg::OP_TRACK_ID, 17'sd0, 32'd10);
		send_event(tgc_pkg::OP_TRACK_ID, -17'sd1, 32'd50);
		send_event(tgc_pkg::OP_TRACK_ID, 17'sd65535, 32'd100);
		send_event(tgc_pkg::OP_POS_X, 17'sd65535, 32'd150);
		send_event(tgc_pkg::OP_POS_Y, -17'sd1, 32'd200);
		send_event(tgc_pkg::OP_TRACK_ID, -17'sd1, 32'd300);
		// long press across the time wrap
		send_event(tgc_pkg::OP_TRACK_ID, 17'sd7, 32'hFFFF_FF00);
		send_event(tgc_pkg::OP_POS_X, 17'sd65530, 32'hFFFF_FF80);
		send_event(tgc_pkg::OP_TRACK_ID, -17'sd1, 32'h0000_0400);
		send_event(tgc_pkg::OP_TRACK_ID, 17'sd1, 32'd2000);
		send_event(tgc_pkg::OP_POS_X, 17'sd65520, 32'd2010);
		send_event(tgc_pkg::OP_TRACK_ID, -17'sd1, 32'd2050);
		// fill the table, then one touch-down too many
		for (int i = 0; i <= SLOTS; i++)
			send_event(tgc_pkg::OP_TRACK_ID, 17'(i), 32'd3000 + 32'(i));
		now_t = 32'd4000;
	endtask

	task automatic gesture_run(int style);
		logic [15:0] px, py;
		logic [31:0] t0;
		logic signed [16:0] v;
		int d, ax, ay, dur, n;
		src_quiet = ($urandom_range(0, 6) == 0);
		t0 = now_t;
		if (style < 3) begin
			send_event(tgc_pkg::OP_TRACK_ID, 17'($urandom_range(0, 65535)), t0);
			sb.top_point(px, py);
			case (style)
				0: begin
					d = near(sb.thr.tap_move_lim);
					dur = near(sb.thr.tap_max_time);
				end
				1: begin
					d = near(sb.thr.tap_move_lim);
					dur = near(sb.thr.long_press_time);
				end
				default: begin
					d = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
						: near(sb.thr.swipe_move_min);
					dur = $urandom_range(0, 1000);
				end
			endcase
			ax = $urandom_range(0, d);
			if ($urandom_range(0, 5) == 0)
				ax = d / 2;
			ay = d - ax;
			if ($urandom_range(0, 1))
				ax = -ax;
			if ($urandom_range(0, 1))
				ay = -ay;
			repeat ($urandom_range(0, 2)) begin
				if ($urandom_range(0, 7) == 0)
					v = -17'sd1;
				else
					v = coord_at(px, int'($urandom_range(0, 200)) - 100);
				send_event($urandom_range(0, 1) ? tgc_pkg::OP_POS_X : tgc_pkg::OP_POS_Y, v,
					t0 + 32'($urandom_range(0, dur)));
			end
			if ($urandom_range(0, 1)) begin
				if (ax != 0 || $urandom_range(0, 1))
					send_event(tgc_pkg::OP_POS_X, coord_at(px, ax), t0 + 32'(dur / 2));
				if (ay != 0 || $urandom_range(0, 1))
					send_event(tgc_pkg::OP_POS_Y, coord_at(py, ay), t0 + 32'(dur / 2));
			end else begin
				if (ay != 0 || $urandom_range(0, 1))
					send_event(tgc_pkg::OP_POS_Y, coord_at(py, ay), t0 + 32'(dur / 2));
				if (ax != 0 || $urandom_range(0, 1))
					send_event(tgc_pkg::OP_POS_X, coord_at(px, ax), t0 + 32'(dur / 2));
			end
			send_event(tgc_pkg::OP_TRACK_ID, -17'sd1, t0 + 32'(dur));
			now_t = t0 + 32'(dur) + 32'(pause_ms());
		end else if (style == 3) begin
			n = $urandom_range(2, SLOTS + 1);
			repeat (n) begin
				send_event(tgc_pkg::OP_TRACK_ID, 17'($urandom_range(0, 65535)), now_t);
				now_t += 32'($urandom_range(0, 50));
			end
			repeat ($urandom_range(0, 4))
				send_event($urandom_range(0, 1) ? tgc_pkg::OP_POS_X : tgc_pkg::OP_POS_Y,
					17'($urandom_range(0, 65535)), now_t);
			repeat (n) begin
				now_t += 32'($urandom_range(0, 300));
				send_event(tgc_pkg::OP_TRACK_ID, -17'sd1, now_t);
			end
		end else begin
			repeat ($urandom_range(1, 4)) begin
				if ($urandom_range(0, 3) == 0)
					v = -17'sd1;
				else
					v = 17'($urandom_range(0, 65535));
				send_event(tgc_pkg::op_t'($urandom_range(0, 3)), v,
					$urandom_range(0, 1) ? $urandom() : now_t);
			end
		end
	endtask

	initial begin
		int hold;
		gesture_t got;
		out_ready = 1'b0;
		hold = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				got.kind = tgc_pkg::kind_t'(gesture_kind);
				got.x = gesture_x;
				got.y = gesture_y;
				got.dx = delta_x;
				got.dy = delta_y;
				sb.check_gesture(got);
			end
			if ($urandom_range(0, 299) == 0)
				snk_quiet = !snk_quiet;
			if (hold == 0)
				hold = pick_gap(snk_quiet);
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		#10_000_000;
		$display("tb: failure");
		$finish;
	end

	initial begin
		int r;
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		op = '0;
		value = '0;
		now_ms = '0;
		now_t = '0;
		items = 0;
		src_quiet = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		for (int ph = 0; ph < NPHASE; ph++) begin
			if (ph > 0) begin
				drain();
				set_thresholds(phase_setting(ph));
			end
			while (items < 26 + (ph + 1) * PER_PHASE) begin
				r = $urandom_range(0, 99);
				if (r < 35)
					gesture_run(0);
				else if (r < 50)
					gesture_run(1);
				else if (r < 80)
					gesture_run(2);
				else if (r < 88)
					gesture_run(3);
				else
					gesture_run(4);
			end
		end
		drain();
		repeat (8) @(posedge clk);
		if (sb.expected_q.size() != 0) begin
			sb.mismatches += sb.expected_q.size();
			$display("%0d results never arrived", sb.expected_q.size());
		end
		$display("checked %0d results from %0d events over %0d threshold settings",
			sb.checked, sb.events, NPHASE);
		$display("%0d downs dropped on a full table; taps %0d, double taps %0d, long presses %0d",
			sb.dropped, sb.kind_cnt[tgc_pkg::KIND_TAP], sb.kind_cnt[tgc_pkg::KIND_DOUBLE_TAP],
			sb.kind_cnt[tgc_pkg::KIND_LONG_PRESS]);
		$display("swipes l/r/u/d %0d/%0d/%0d/%0d",
			sb.kind_cnt[tgc_pkg::KIND_SWIPE_LEFT], sb.kind_cnt[tgc_pkg::KIND_SWIPE_RIGHT],
			sb.kind_cnt[tgc_pkg::KIND_SWIPE_UP], sb.kind_cnt[tgc_pkg::KIND_SWIPE_DOWN]);
		if (sb.mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ filelist.f @@
design/tgc_pkg.sv
design/tgc_cfg_regs.sv
design/tgc_slot_table.sv
design/tgc_classify.sv
design/touch_gesture_classifier.sv
test/tb.sv
